// File: rtl/dcs_pkg.sv
`default_nettype none
//------------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants for the difference constraint solver.
//------------------------------------------------------------------------------
package dcs_pkg;

   localparam int DefaultMaxVars  = 32;
   localparam int DefaultMaxEdges = 256;
   localparam int VarWidth        = 6;
   localparam int BoundWidth      = 16;
   localparam int ValueWidth      = 32;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_POP,
      ST_HEAD,
      ST_EDGE_RD,
      ST_EDGE_WAIT,
      ST_RELAX,
      ST_OUT_RD,
      ST_OUT,
      ST_FAIL,
      ST_CLEAR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_edge;    // store the incoming edge
      logic init_step;    // initialize one variable (index = sweep counter)
      logic init_start;   // reset sweep counter
      logic pop;          // pop the ring head into u
      logic head_rd;      // fetch list head of u
      logic edge_rd;      // read the current edge
      logic relax_rd;     // read distance and flags of the edge target
      logic relax;        // apply relaxation for the current edge
      logic out_rd;       // read distance of the sweep counter variable
      logic out_valid;    // present a result beat
      logic out_fail;     // present the infeasible beat
      logic out_hold;     // result register is stalled
      logic clear_step;   // clear one list head
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ring_empty;
      logic u_valid;      // popped entry is a real variable
      logic edge_valid;   // current link points at an edge
      logic fail;         // enqueue count exceeded
      logic sweep_done;   // sweep counter at the last variable in use
      logic clear_done;   // sweep counter at the last list head
   } status_type;

endpackage : dcs_pkg
`default_nettype wire

// File: rtl/dcs_datapath.sv
`default_nettype none
//------------------------------------------------------------------------------
// dcs_datapath
// Edge store, distance tables, work ring and relaxation arithmetic.
//------------------------------------------------------------------------------
module dcs_datapath #(
   parameter int MAX_VARS  = dcs_pkg::DefaultMaxVars,
   parameter int MAX_EDGES = dcs_pkg::DefaultMaxEdges
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dcs_pkg::cmd_type          cmd,
   output      dcs_pkg::status_type       status,
   input  wire logic [5:0]                csr_num_vars,
   input  wire logic [5:0]                req_from_var,
   input  wire logic [5:0]                req_to_var,
   input  wire logic signed [15:0]        req_bound,
   output      logic [5:0]                rsp_var_index,
   output      logic signed [31:0]        rsp_var_value,
   output      logic                      rsp_infeasible,
   output      logic                      rsp_edges_dropped,
   output      logic                      rsp_is_last
);
   import dcs_pkg::*;

   localparam int VW = $clog2(MAX_VARS + 1);
   localparam int EW = $clog2(MAX_EDGES + 1);
   localparam int RW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int CW = $clog2(MAX_VARS + 2);

   // Effective variable count.
   logic [VW-1:0] n;
   always_comb begin
      if (csr_num_vars == 6'd0) begin
         n = VW'(1);
      end else if (32'(csr_num_vars) > 32'(MAX_VARS)) begin
         n = VW'(MAX_VARS);
      end else begin
         n = VW'(csr_num_vars);
      end
   end

   // Edge memories.
   logic [EW-1:0]         link_mem   [1:MAX_EDGES];
   logic [VW-1:0]         target_mem [1:MAX_EDGES];
   logic signed [15:0]    gain_mem   [1:MAX_EDGES];
   logic [EW-1:0]         head_ff    [0:MAX_VARS];
   logic [EW:0]           total_ff;
   logic                  overflow_ff;

   logic [VW-1:0] from_v, to_v;
   logic          edge_ok;
   assign from_v  = VW'(req_from_var);
   assign to_v    = VW'(req_to_var);
   assign edge_ok = (req_from_var != 6'd0) && (32'(req_from_var) <= 32'(n)) &&
                    (req_to_var != 6'd0) && (32'(req_to_var) <= 32'(n));

   logic [EW-1:0] new_e;
   assign new_e = total_ff[EW-1:0] + EW'(1);

   always_ff @(posedge clock) begin
      if (cmd.load_edge && edge_ok && (total_ff < (EW+1)'(MAX_EDGES))) begin
         link_mem[new_e]   <= head_ff[from_v];
         target_mem[new_e] <= to_v;
         gain_mem[new_e]   <= req_bound;
      end
   end

   // Solve state.
   logic [VW-1:0]         u_ff;
   logic [EW-1:0]         e_ff;
   logic [VW-1:0]         v_ff;
   logic signed [15:0]    g_ff;
   logic signed [31:0]    du_ff;
   logic signed [31:0]    dv_ff;
   logic                  inr_v_ff;
   logic [CW-1:0]         cnt_v_ff;
   logic [VW-1:0]         sweep_ff;
   logic                  fail_ff;

   logic signed [31:0]    dist_mem [1:MAX_VARS];
   logic [CW-1:0]         cnt_mem  [1:MAX_VARS];
   logic                  inr_ff   [1:MAX_VARS];
   logic [VW-1:0]         ring_mem [0:MAX_VARS-1];
   logic [RW-1:0]         rd_ff;
   logic [VW-1:0]         ring_cnt_ff;
   logic [VW-1:0]         ring_rd_data;

   // Relaxation arithmetic.
   logic signed [33:0] cand;
   logic signed [31:0] cand_sat;
   logic               v_ok;
   logic               better;
   logic               do_enq;
   logic [CW-1:0]      cnt_next;
   assign cand = 34'(du_ff) - 34'(g_ff);
   always_comb begin
      if (cand > 34'sd2147483647) begin
         cand_sat = 32'sh7fffffff;
      end else if (cand < -34'sd2147483648) begin
         cand_sat = 32'sh80000000;
      end else begin
         cand_sat = cand[31:0];
      end
   end
   assign v_ok     = (v_ff != '0) && (v_ff <= n);
   assign better   = v_ok && (34'(dv_ff) < cand);
   assign do_enq   = better && !inr_v_ff;
   assign cnt_next = cnt_v_ff + CW'(1);

   logic [RW-1:0] wr_idx;
   always_comb begin
      logic [RW:0] s;
      s = (RW+1)'(rd_ff) + (RW+1)'(ring_cnt_ff);
      if (s >= (RW+1)'(MAX_VARS)) begin
         s = s - (RW+1)'(MAX_VARS);
      end
      wr_idx = s[RW-1:0];
   end

   logic [RW-1:0] sweep_idx;
   assign sweep_idx = RW'(sweep_ff - VW'(1));

   always_ff @(posedge clock) begin
      // A head slot written by an initialization step is forwarded.
      if (cmd.init_step && (sweep_idx == rd_ff)) begin
         ring_rd_data <= sweep_ff;
      end else begin
         ring_rd_data <= ring_mem[rd_ff];
      end
      if (cmd.init_step) begin
         ring_mem[sweep_idx] <= sweep_ff;
      end else if (cmd.relax && do_enq && !(32'(cnt_next) > 32'(n))) begin
         ring_mem[wr_idx] <= v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_step) begin
         dist_mem[sweep_ff] <= '0;
         cnt_mem[sweep_ff]  <= CW'(1);
         inr_ff[sweep_ff]   <= 1'b1;
      end else begin
         if (cmd.pop) begin
            // u is taken from the registered ring head.
         end
         if (cmd.head_rd && status.u_valid) begin
            inr_ff[u_ff] <= 1'b0;
         end
         if (cmd.relax && better) begin
            dist_mem[v_ff] <= cand_sat;
            if (!inr_v_ff) begin
               cnt_mem[v_ff] <= cnt_next;
               inr_ff[v_ff]  <= 1'b1;
            end
         end
      end
      // A self loop raises the distance of u for the edges that follow.
      if (cmd.head_rd) begin
         du_ff <= dist_mem[u_ff];
      end else if (cmd.relax && better && (v_ff == u_ff)) begin
         du_ff <= cand_sat;
      end
      if (cmd.relax_rd) begin
         dv_ff    <= dist_mem[v_ff];
         cnt_v_ff <= cnt_mem[v_ff];
         inr_v_ff <= inr_ff[v_ff];
      end
      if (cmd.out_rd) begin
         dv_ff <= dist_mem[sweep_ff];
      end
      if (cmd.edge_rd) begin
         v_ff <= target_mem[e_ff];
         g_ff <= gain_mem[e_ff];
      end
      if (cmd.pop) begin
         u_ff <= ring_rd_data;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         overflow_ff <= 1'b0;
         rd_ff       <= '0;
         ring_cnt_ff <= '0;
         sweep_ff    <= '0;
         fail_ff     <= 1'b0;
         e_ff        <= '0;
         for (int i = 0; i <= MAX_VARS; i++) begin
            head_ff[i] <= '0;
         end
      end else begin
         if (cmd.load_edge && edge_ok) begin
            if (total_ff < (EW+1)'(MAX_EDGES)) begin
               head_ff[from_v] <= new_e;
               total_ff        <= total_ff + (EW+1)'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (cmd.init_start) begin
            sweep_ff    <= VW'(1);
            rd_ff       <= '0;
            ring_cnt_ff <= '0;
            fail_ff     <= 1'b0;
         end else if (cmd.init_step) begin
            sweep_ff    <= sweep_ff + VW'(1);
            ring_cnt_ff <= ring_cnt_ff + VW'(1);
         end else if (cmd.out_valid && !cmd.out_hold) begin
            sweep_ff <= (sweep_ff == n) ? '0 : sweep_ff + VW'(1);
         end else if (cmd.out_fail && !cmd.out_hold) begin
            sweep_ff <= '0;
         end else if (cmd.clear_step) begin
            head_ff[sweep_ff] <= '0;
            sweep_ff          <= sweep_ff + VW'(1);
            total_ff          <= '0;
            overflow_ff       <= 1'b0;
         end
         if (cmd.pop) begin
            rd_ff       <= (32'(rd_ff) == MAX_VARS - 1) ? '0 : rd_ff + RW'(1);
            ring_cnt_ff <= ring_cnt_ff - VW'(1);
         end
         if (cmd.head_rd) begin
            e_ff <= head_ff[u_ff];
         end
         if (cmd.relax) begin
            e_ff <= link_mem[e_ff];
            if (do_enq) begin
               if (32'(cnt_next) > 32'(n)) begin
                  fail_ff <= 1'b1;
               end else begin
                  ring_cnt_ff <= ring_cnt_ff + VW'(1);
               end
            end
         end
      end
   end

   assign status.ring_empty = (ring_cnt_ff == '0);
   assign status.u_valid    = (u_ff != '0) && (u_ff <= n);
   assign status.edge_valid = (e_ff != '0) && (32'(e_ff) <= MAX_EDGES);
   assign status.fail       = fail_ff;
   assign status.sweep_done = (sweep_ff == n);
   assign status.clear_done = (32'(sweep_ff) == MAX_VARS);

   assign rsp_var_index     = cmd.out_fail ? 6'd0 : 6'(sweep_ff);
   assign rsp_var_value     = cmd.out_fail ? 32'sd0 : dv_ff;
   assign rsp_infeasible    = cmd.out_fail;
   assign rsp_edges_dropped = overflow_ff;
   assign rsp_is_last       = cmd.out_fail || (sweep_ff == n);

`ifndef NO_ASSERTIONS
   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      32'(ring_cnt_ff) <= MAX_VARS)
      else $error("work ring count exceeds capacity");
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= MAX_EDGES)
      else $error("edge total exceeds capacity");
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> (32'($past(total_ff)) == MAX_EDGES))
      else $error("overflow flagged with free edge slots");
`endif

endmodule : dcs_datapath
`default_nettype wire

// File: rtl/dcs_ctrl.sv
`default_nettype none
//------------------------------------------------------------------------------
// dcs_ctrl
// Sequencer for edge loading, the relaxation loop and result output.
//------------------------------------------------------------------------------
module dcs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_last_edge,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      dcs_pkg::cmd_type      cmd,
   input  wire dcs_pkg::status_type   status
);
   import dcs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.out_hold = rsp_stall;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_edge = 1'b1;
               if (req_last_edge) begin
                  cmd.init_start = 1'b1;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            // Ring head read is registered, so the pop takes u from the registered head.
            if (status.fail) begin
               state_in = ST_FAIL;
            end else if (status.ring_empty) begin
               cmd.init_start = 1'b1;
               state_in = ST_OUT_RD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in = status.u_valid ? ST_EDGE_RD : ST_POP;
         end
         ST_EDGE_RD: begin
            if (status.fail) begin
               state_in = ST_FAIL;
            end else if (status.edge_valid) begin
               cmd.edge_rd = 1'b1;
               state_in = ST_EDGE_WAIT;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_EDGE_WAIT: begin
            cmd.relax_rd = 1'b1;
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            cmd.relax = 1'b1;
            state_in = ST_EDGE_RD;
         end
         ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid     = 1'b1;
            cmd.out_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.sweep_done) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_FAIL: begin
            rsp_valid    = 1'b1;
            cmd.out_fail = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> req_stall)
      else $error("input taken outside load state");
   a_rsp_states: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_OUT || state_ff == ST_FAIL))
      else $error("result beat outside output states");
   a_fail_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FAIL) |-> status.fail)
      else $error("infeasible beat without detection");
`endif

endmodule : dcs_ctrl
`default_nettype wire

// File: rtl/difference_constraint_solver.sv
`default_nettype none
//------------------------------------------------------------------------------
// difference_constraint_solver
// Loads difference constraints as edges and solves them by queue relaxation.
//------------------------------------------------------------------------------
// Each accepted beat takes one constraint. A beat with last_edge starts a solve:
// an initialization sweep over the variables in use, then the relaxation
// loop, which pops a variable, reads its list head and, for each edge visited,
// reads the edge, reads the target's distance and flags and relaxes it.
// Result beats, or one infeasible beat, then leave, each held while stalled, and a
// clearing pass empties list heads 0 to MAX_VARS before the next beat is taken.
module difference_constraint_solver #(
   parameter int MAX_VARS  = dcs_pkg::DefaultMaxVars,
   parameter int MAX_EDGES = dcs_pkg::DefaultMaxEdges
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [5:0]         csr_wr_data,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [5:0]         req_from_var,
   input  wire logic [5:0]         req_to_var,
   input  wire logic signed [15:0] req_bound,
   input  wire logic               req_last_edge,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [5:0]         rsp_var_index,
   output      logic signed [31:0] rsp_var_value,
   output      logic               rsp_infeasible,
   output      logic               rsp_edges_dropped,
   output      logic               rsp_is_last
);
   import dcs_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [5:0] num_vars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vars_ff <= 6'd32;
      end else if (csr_wr_en) begin
         num_vars_ff <= csr_wr_data;
      end
   end

   dcs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_last_edge (req_last_edge),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   dcs_datapath #(
      .MAX_VARS  (MAX_VARS),
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_num_vars      (num_vars_ff),
      .req_from_var      (req_from_var),
      .req_to_var        (req_to_var),
      .req_bound         (req_bound),
      .rsp_var_index     (rsp_var_index),
      .rsp_var_value     (rsp_var_value),
      .rsp_infeasible    (rsp_infeasible),
      .rsp_edges_dropped (rsp_edges_dropped),
      .rsp_is_last       (rsp_is_last)
   );

endmodule : difference_constraint_solver
`default_nettype wire

// File: tb/sv/difference_constraint_solver_checker.sv
//------------------------------------------------------------------------------
// difference_constraint_solver_checker
// Watches the constraint, result and register ports of the solver, keeps its
// own copy of the edge store, solves each job by queue relaxation and compares
// every result beat field by field with the oldest predicted value.
//------------------------------------------------------------------------------
module difference_constraint_solver_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [dcs_pkg::VarWidth-1:0]  csr_wr_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [dcs_pkg::VarWidth-1:0]  req_from_var,
   input  logic [dcs_pkg::VarWidth-1:0]  req_to_var,
   input  logic signed [15:0]            req_bound,
   input  logic                          req_last_edge,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [dcs_pkg::VarWidth-1:0]  rsp_var_index,
   input  logic signed [31:0]            rsp_var_value,
   input  logic                          rsp_infeasible,
   input  logic                          rsp_edges_dropped,
   input  logic                          rsp_is_last,
   output int                            fail_count,
   output int                            pending,
   output int                            beats_seen,
   output int                            jobs_infeasible
);
   timeunit 1ns;
   timeprecision 1ps;
   import dcs_pkg::*;

   localparam int NV = DefaultMaxVars;
   localparam int NE = DefaultMaxEdges;

   typedef struct {
      logic [VarWidth-1:0] index;
      logic signed [31:0]  value;
      logic                infeasible;
      logic                dropped;
      logic                is_last;
   } solution_beat_t;

   solution_beat_t solution_q[$];

   logic [VarWidth-1:0] var_count;
   logic [8:0]          list_first[0:NV];
   logic [8:0]          next_edge[1:NE];
   logic [VarWidth-1:0] edge_to[1:NE];
   logic signed [15:0]  edge_bound[1:NE];
   int                  edges_held;
   bit                  lost_edge;
   int                  level[1:NV];

   assign pending = solution_q.size();

   function automatic int live_vars();
      if (var_count == 0) return 1;
      if (var_count > NV) return NV;
      return int'(var_count);
   endfunction

   // Returns 1 when some variable is queued more than n times (positive cycle).
   function automatic bit relax_all(int n);
      int     times[1:NV];
      bit     queued[1:NV];
      int     ring[0:NV-1];
      int     rd, cnt, u, v, e;
      longint cand;
      for (int i = 1; i <= n; i++) begin
         level[i] = 0;
         times[i] = 1;
         queued[i] = 1;
         ring[i-1] = i;
      end
      rd = 0;
      cnt = n;
      while (cnt > 0) begin
         u = ring[rd];
         rd = (rd + 1) % NV;
         cnt--;
         if (u < 1 || u > n) continue;
         queued[u] = 0;
         e = list_first[u];
         while (e >= 1 && e <= NE) begin
            v = edge_to[e];
            cand = longint'(level[u]) - longint'(edge_bound[e]);
            if (v >= 1 && v <= n && longint'(level[v]) < cand) begin
               if (cand > 64'sd2147483647) level[v] = 32'sh7fffffff;
               else if (cand < -64'sd2147483648) level[v] = 32'sh80000000;
               else level[v] = int'(cand);
               if (!queued[v]) begin
                  times[v]++;
                  if (times[v] > n) return 1;
                  ring[(rd + cnt) % NV] = v;
                  cnt++;
                  queued[v] = 1;
               end
            end
            e = next_edge[e];
         end
      end
      return 0;
   endfunction

   task automatic take_constraint();
      int             n;
      solution_beat_t b;
      n = live_vars();
      if (req_from_var >= 1 && req_from_var <= n && req_to_var >= 1 && req_to_var <= n) begin
         if (edges_held < NE) begin
            edges_held++;
            next_edge[edges_held] = list_first[req_from_var];
            edge_to[edges_held] = req_to_var;
            edge_bound[edges_held] = req_bound;
            list_first[req_from_var] = 9'(edges_held);
         end else begin
            lost_edge = 1;
         end
      end
      if (!req_last_edge) return;
      if (relax_all(n)) begin
         b = '{index: '0, value: '0, infeasible: 1'b1, dropped: lost_edge, is_last: 1'b1};
         solution_q.push_back(b);
         jobs_infeasible++;
      end else begin
         for (int i = 1; i <= n; i++) begin
            b = '{index: VarWidth'(i), value: level[i], infeasible: 1'b0,
                  dropped: lost_edge, is_last: (i == n)};
            solution_q.push_back(b);
         end
      end
      for (int i = 0; i <= NV; i++) list_first[i] = '0;
      edges_held = 0;
      lost_edge = 0;
   endtask

   task automatic check_beat();
      solution_beat_t b;
      beats_seen++;
      if (solution_q.size() == 0) begin
         $display("%0t: unexpected result beat index=%0d value=%0d", $time,
                  rsp_var_index, rsp_var_value);
         fail_count++;
         return;
      end
      b = solution_q.pop_front();
      if (rsp_var_index !== b.index || rsp_var_value !== b.value ||
          rsp_infeasible !== b.infeasible || rsp_edges_dropped !== b.dropped ||
          rsp_is_last !== b.is_last) begin
         $display("%0t: mismatch expected idx=%0d val=%0d inf=%0b drop=%0b last=%0b",
                  $time, b.index, b.value, b.infeasible, b.dropped, b.is_last);
         $display("%0t:          actual   idx=%0d val=%0d inf=%0b drop=%0b last=%0b",
                  $time, rsp_var_index, rsp_var_value, rsp_infeasible,
                  rsp_edges_dropped, rsp_is_last);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      beats_seen = 0;
      jobs_infeasible = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         var_count = 6'd32;
         for (int i = 0; i <= NV; i++) list_first[i] = '0;
         edges_held = 0;
         lost_edge = 0;
         solution_q.delete();
      end else begin
         if (csr_wr_en) var_count = csr_wr_data;
         if (req_valid && !req_stall) take_constraint();
         if (rsp_valid && !rsp_stall) check_beat();
      end
   end

endmodule : difference_constraint_solver_checker

// File: tb/sv/difference_constraint_solver_tb.sv
//------------------------------------------------------------------------------
// difference_constraint_solver_tb
// Drives constraint jobs through the solver under several variable counts and
// idle patterns, including a store overflow and a long result hold-off; the
// checker module predicts and compares every result beat.
//------------------------------------------------------------------------------
module difference_constraint_solver_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dcs_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [VarWidth-1:0] csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [VarWidth-1:0] req_from_var = '0;
   logic [VarWidth-1:0] req_to_var = '0;
   logic signed [15:0]  req_bound = '0;
   logic                req_last_edge = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VarWidth-1:0] rsp_var_index;
   logic signed [31:0]  rsp_var_value;
   logic                rsp_infeasible;
   logic                rsp_edges_dropped;
   logic                rsp_is_last;

   int fail_count, pending, beats_seen, jobs_infeasible;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_go = 0;
   int hold_done = 0;
   int jobs_sent = 0;
   int items_sent = 0;

   always #6 clock = ~clock;

   difference_constraint_solver dut (.*);

   difference_constraint_solver_checker checker_i (.*);

   // Receiver side: random stalls, plus one long hold-off when requested.
   always @(posedge clock) begin
      if (hold_go && hold_done < 400) begin
         hold_done++;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_beat(int from_v, int to_v, int bound, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_from_var <= VarWidth'(from_v);
      req_to_var <= VarWidth'(to_v);
      req_bound <= 16'(bound);
      req_last_edge <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (last) jobs_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // Clearing pass and pipeline tail before the block is idle again.
      repeat (80) @(posedge clock);
   endtask

   task automatic write_var_count(int v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= VarWidth'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_job(int n);
      int len, f, t, b;
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(9) == 0) begin
            f = $urandom_range(0, 63);
            t = $urandom_range(0, 63);
         end else begin
            f = $urandom_range(1, n);
            t = $urandom_range(1, n);
         end
         case ($urandom_range(3))
            0, 1: b = $urandom_range(0, 40) - 8;
            2: b = $urandom_range(0, 65535);
            default: b = $urandom_range(0, 300);
         endcase
         send_beat(f, t, b, k == len - 1);
      end
   endtask

   task automatic random_phase(int vars_reg, int jobs);
      int n;
      n = (vars_reg == 0) ? 1 : (vars_reg > 32 ? 32 : vars_reg);
      write_var_count(vars_reg);
      repeat (jobs) random_job(n);
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed jobs with five variables.
      write_var_count(5);
      send_beat(1, 2, -3, 0);
      send_beat(2, 3, 32767, 0);
      send_beat(3, 4, -32768, 0);
      send_beat(5, 1, 0, 0);
      send_beat(0, 2, 5, 0);
      send_beat(6, 1, 1, 0);
      send_beat(63, 63, -1, 0);
      send_beat(4, 5, 7, 1);
      // Positive cycle through two variables.
      send_beat(1, 2, -1, 0);
      send_beat(2, 1, 0, 1);
      // A job whose only beat carries no usable edge.
      send_beat(0, 0, 0, 1);
      // Self loop with positive gain.
      send_beat(3, 3, -1, 1);
      send_beat(2, 5, -32768, 0);
      send_beat(5, 4, -32768, 0);
      send_beat(1, 1, 0, 1);
      drain();

      // Full variable count, no idling, one job that overflows the edge store.
      write_var_count(32);
      for (int k = 0; k < 258; k++)
         send_beat($urandom_range(1, 32), $urandom_range(1, 32),
                   $urandom_range(0, 2000), 0);
      send_beat(32, 1, -5, 1);
      drain();
      random_phase(32, 3);

      send_idle_pct = 58;
      random_phase(1, 3);
      send_idle_pct = 0;
      recv_stall_pct = 58;
      random_phase(0, 3);
      send_idle_pct = 25;
      recv_stall_pct = 25;
      random_phase(63, 4);

      // Long receiver hold-off while the sender keeps offering jobs.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_var_count(17);
      hold_go = 1;
      repeat (4) random_job(17);
      drain();

      recv_stall_pct = 25;
      random_phase(7, 4);

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Ran %0d constraint beats in %0d jobs over variable counts 0 to 63.",
               items_sent, jobs_sent);
      $display("Checked %0d result beats, %0d jobs infeasible, one edge overflow job.",
               beats_seen, jobs_infeasible);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule : difference_constraint_solver_tb

// File: sim.f
rtl/dcs_pkg.sv
rtl/dcs_datapath.sv
rtl/dcs_ctrl.sv
rtl/difference_constraint_solver.sv
tb/sv/difference_constraint_solver_checker.sv
tb/sv/difference_constraint_solver_tb.sv
